// ===== design/dshot_telemetry_gcr_decoder_macros.svh =====
// Assertion helpers for the GCR telemetry decoder.
`ifndef DSHOT_TELEMETRY_GCR_DECODER_MACROS_SVH
`define DSHOT_TELEMETRY_GCR_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define DGCR_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DGCR_ASSERT(lbl, prop) \
  `DGCR_ASSERT_MSG(lbl, clk_i, rst_ni, prop, "dgcr assertion failed")
`else
`define DGCR_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`define DGCR_ASSERT(lbl, prop)
`endif
`endif

// ===== design/dgcr_pkg.sv =====
`default_nettype none
package dgcr_pkg;

  localparam int unsigned DurW      = 15;
  localparam int unsigned FrameBits = 21;
  localparam int unsigned DivNumW   = 20;
  localparam int unsigned DivDenW   = 16;
  localparam int unsigned DivCntW   = 5;
  localparam logic [19:0] ErpmNum   = 20'd600000;
  localparam logic [4:0]  SymBad    = 5'h10;
  localparam logic [11:0] PayloadNoPeriod = 12'h0ff;

  typedef struct packed {
    logic [14:0] first_duration;
    logic        first_level;
    logic [14:0] second_duration;
    logic        second_level;
    logic        last_item;
  } dgcr_in_t;

  typedef struct packed {
    logic        telemetry_ok;
    logic [11:0] payload_code;
    logic [15:0] period_value;
    logic [19:0] erpm_times_100;
  } dgcr_out_t;

  // queued item plus front classification
  typedef struct packed {
    dgcr_in_t data;
    logic     first_zero;
    logic     second_zero;
  } dgcr_item_t;

  typedef struct packed {
    logic        start;
    logic [19:0] num;
    logic [15:0] den;
  } dgcr_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [19:0] quot;
  } dgcr_div_rsp_t;

  // GCR 5b->4b; bit 4 set marks an illegal symbol
  function automatic logic [4:0] gcr_decode(input logic [4:0] sym);
    logic [4:0] r;
    case (sym)
      5'h09: r = 5'h09;
      5'h0a: r = 5'h0a;
      5'h0b: r = 5'h0b;
      5'h0d: r = 5'h0d;
      5'h0e: r = 5'h0e;
      5'h0f: r = 5'h0f;
      5'h12: r = 5'h02;
      5'h13: r = 5'h03;
      5'h15: r = 5'h05;
      5'h16: r = 5'h06;
      5'h17: r = 5'h07;
      5'h19: r = 5'h00;
      5'h1a: r = 5'h08;
      5'h1b: r = 5'h01;
      5'h1d: r = 5'h04;
      5'h1e: r = 5'h0c;
      default: r = SymBad;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/dshot_telemetry_gcr_decoder.sv =====
// Bidirectional DShot GCR telemetry decoder.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// captured pulse item, two duration/level segments plus a last-item flag.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transaction per
// frame, issued after the item marked last; other items give nothing.
// Config: cfg_we_i writes bit_length (ticks per bit, 0 acts as 1); write only
// while idle. Reset value is 32.
// Each nonzero segment before the first zero one runs through the shared
// 20-step restoring divider; the last item then adds frame decode and the
// eRPM division, which is skipped when the period is zero. A two-entry
// queue in front takes new items while the back end is busy; in_stall_o
// rises only when that queue is full.
// A finished result sits in the output register while out_stall_i is high;
// the back end then waits in its final step but the queue keeps filling.
// Reset (rst_ni low, async) empties the queue, clears the frame shift state
// and drops any pending result.
`default_nettype none
`include "dshot_telemetry_gcr_decoder_macros.svh"
module dshot_telemetry_gcr_decoder (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dgcr_pkg::dgcr_in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dgcr_pkg::dgcr_out_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire  [14:0]          cfg_wdata_i
);
  import dgcr_pkg::*;

  logic          [14:0] bit_len_q;
  logic                 item_valid;
  dgcr_item_t           item;
  logic                 pop;
  dgcr_div_req_t        div_req;
  dgcr_div_rsp_t        div_rsp;

  // bit_length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_len_q <= 15'd32;
    end else if (cfg_we_i) begin
      bit_len_q <= cfg_wdata_i;
    end
  end

  // front end: queue + zero-duration classification
  dgcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  // shared divider: segment rounding and eRPM
  dgcr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // back end: bit capture, frame decode, result register
  dgcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bit_len_i    (bit_len_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_o        (out_data_o)
  );

  `DGCR_ASSERT(a_no_pop_empty, pop |-> item_valid)
  `DGCR_ASSERT(a_div_no_restart, div_req.start |-> !div_rsp.busy)
  `DGCR_ASSERT(a_div_done_pulse, div_rsp.done |=> !div_rsp.done)

endmodule
`default_nettype wire

// ===== design/dgcr_front.sv =====
`default_nettype none
module dgcr_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  dgcr_pkg::dgcr_in_t      in_data_i,
  output logic                    item_valid_o,
  output dgcr_pkg::dgcr_item_t    item_o,
  input  wire                     pop_i
);
  import dgcr_pkg::*;

  // two-entry queue
  dgcr_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  dgcr_item_t cls;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cls.data        = in_data_i;
    cls.first_zero  = (in_data_i.first_duration == '0);
    cls.second_zero = (in_data_i.second_duration == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

endmodule
`default_nettype wire

// ===== design/dgcr_div.sv =====
`default_nettype none
module dgcr_div (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  dgcr_pkg::dgcr_div_req_t req_i,
  output dgcr_pkg::dgcr_div_rsp_t rsp_o
);
  import dgcr_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic [DivDenW-1:0] rem_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== design/dgcr_back.sv =====
`default_nettype none
module dgcr_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  [14:0]             bit_len_i,
  input  wire                     item_valid_i,
  input  dgcr_pkg::dgcr_item_t    item_i,
  output logic                    pop_o,
  output dgcr_pkg::dgcr_div_req_t div_req_o,
  input  dgcr_pkg::dgcr_div_rsp_t div_rsp_i,
  output logic                    res_valid_o,
  input  wire                     res_stall_i,
  output dgcr_pkg::dgcr_out_t     res_o
);
  import dgcr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SEG  = 7'b0000010,
    S_DIVW = 7'b0000100,
    S_END  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_ERPM = 7'b0100000,
    S_POST = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  dgcr_item_t  item_q;
  logic        seg_q;
  logic [20:0] shift_q;
  logic [4:0]  seen_q;
  logic        stop_q;
  logic        ok_q;
  logic [11:0] payload_q;
  logic [15:0] period_q;
  logic [19:0] erpm_q;
  logic        res_valid_q;
  logic        res_valid_d;
  dgcr_out_t   res_q;
  // ERPM division reuses S_DIVW; a done there on the FIN path is told apart
  // by fin_q
  logic        fin_q;

  logic [14:0] len;
  logic [14:0] dur;
  logic        lvl, zero;
  logic        out_free;
  logic [20:0] run_shift;
  logic [4:0]  run_seen;
  logic [4:0]  pad;
  logic [20:0] padded;
  logic [19:0] raw;
  logic [4:0]  s0, s1, s2, s3;
  logic [15:0] decoded;
  logic        ok_c;
  logic [11:0] payload_c;
  logic [15:0] period_c;

  assign len  = (bit_len_i == '0) ? 15'd1 : bit_len_i;
  assign dur  = seg_q ? item_q.data.second_duration : item_q.data.first_duration;
  assign lvl  = seg_q ? item_q.data.second_level : item_q.data.first_level;
  assign zero = seg_q ? item_q.second_zero : item_q.first_zero;
  assign out_free = !res_valid_q || !res_stall_i;
  assign res_valid_d = (state_q == S_POST && out_free) || (res_valid_q && res_stall_i);

  // run of quotient bits into the frame register
  always_comb begin
    if (div_rsp_i.quot >= 20'(FrameBits)) begin
      run_shift = lvl ? '1 : '0;
    end else begin
      run_shift = (shift_q << div_rsp_i.quot[4:0]) |
                  (lvl ? ~({21{1'b1}} << div_rsp_i.quot[4:0]) : '0);
    end
    if (div_rsp_i.quot >= 20'(5'(FrameBits) - seen_q)) begin
      run_seen = 5'(FrameBits);
    end else begin
      run_seen = seen_q + div_rsp_i.quot[4:0];
    end
  end

  // pad with ones, undo NRZI, GCR, checksum, period
  always_comb begin
    pad = 5'(FrameBits) - seen_q;
    if (seen_q >= 5'(FrameBits)) begin
      padded = shift_q;
    end else begin
      padded = (shift_q << pad) | ~({21{1'b1}} << pad);
    end
    raw = padded[19:0] ^ padded[20:1];
    s0 = gcr_decode(raw[4:0]);
    s1 = gcr_decode(raw[9:5]);
    s2 = gcr_decode(raw[14:10]);
    s3 = gcr_decode(raw[19:15]);
    decoded = {s3[3:0], s2[3:0], s1[3:0], s0[3:0]};
    ok_c = !(s0[4] || s1[4] || s2[4] || s3[4]) &&
           ((decoded[3:0] ^ decoded[7:4] ^ decoded[11:8] ^ decoded[15:12]) == 4'hf);
    payload_c = ok_c ? decoded[15:4] : 12'd0;
    if (!ok_c || payload_c == {PayloadNoPeriod[7:0], 4'hf}) begin
      period_c = '0;
    end else begin
      period_c = 16'({7'd0, payload_c[8:0]} << payload_c[11:9]);
    end
  end

  always_comb begin
    state_d         = state_q;
    pop_o           = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = 20'({1'b0, dur} + {2'b0, len[14:1]});
    div_req_o.den   = {1'b0, len};
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        if (stop_q || zero) begin
          state_d = S_END;
        end else begin
          div_req_o.start = 1'b1;
          state_d         = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_rsp_i.done) begin
          if (fin_q) state_d = S_POST;
          else state_d = seg_q ? S_END : S_SEG;
        end
      end
      S_END: begin
        state_d = item_q.data.last_item ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        state_d = S_ERPM;
      end
      S_ERPM: begin
        div_req_o.num = ErpmNum + 20'(period_q[15:1]);
        div_req_o.den = period_q;
        if (period_q == '0) begin
          state_d = S_POST;
        end else if (!div_rsp_i.busy && !div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          state_d         = S_DIVW;
        end
      end
      S_POST: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_q       <= 1'b0;
      shift_q     <= '0;
      seen_q      <= '0;
      stop_q      <= 1'b0;
      fin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      case (state_q)
        S_IDLE: seg_q <= 1'b0;
        S_SEG: begin
          if (!stop_q && zero) stop_q <= 1'b1;
        end
        S_DIVW: begin
          if (div_rsp_i.done && !fin_q) begin
            shift_q <= run_shift;
            seen_q  <= run_seen;
            seg_q   <= 1'b1;
          end
        end
        S_FIN: fin_q <= 1'b1;
        S_POST: begin
          if (out_free) begin
            shift_q     <= '0;
            seen_q      <= '0;
            stop_q      <= 1'b0;
            fin_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= item_i;
    if (state_q == S_FIN) begin
      ok_q      <= ok_c;
      payload_q <= payload_c;
      period_q  <= period_c;
      erpm_q    <= '0;
    end
    if (state_q == S_DIVW && div_rsp_i.done && fin_q) erpm_q <= div_rsp_i.quot;
    if (state_q == S_POST && out_free) begin
      res_q.telemetry_ok   <= ok_q;
      res_q.payload_code   <= payload_q;
      res_q.period_value   <= period_q;
      res_q.erpm_times_100 <= erpm_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
